/* src/per_module_message_queue_assert.svh */
// Assertion macros used by the message queue engine.
`ifndef PER_MODULE_MESSAGE_QUEUE_ASSERT_SVH
`define PER_MODULE_MESSAGE_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PMMQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmmq assertion failed");

// Next-cycle implication, checked outside reset.
`define PMMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmmq assertion failed");

`endif

/* src/pmmq_pkg.sv */
// Shared constants, codes and types of the per-module message queue.
package pmmq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int MODULE_COUNT = 8;
    localparam int QI_W   = $clog2(QUEUE_DEPTH);
    localparam int IDX_W  = QI_W + 1;
    localparam int MOD_W  = $clog2(MODULE_COUNT);
    localparam int DATA_W = 16;
    localparam int MADDR_W = MOD_W + QI_W;

    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_TAKE      = 2'd1;
    localparam logic [1:0] OP_FIND_MOD  = 2'd2;
    localparam logic [1:0] OP_FIND_SRC  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [MOD_W-1:0]  module_id;
        logic [DATA_W-1:0] msg_handle;
        logic [DATA_W-1:0] msg_source;
        logic [QI_W-1:0]   queue_index;
        logic [QI_W-1:0]   list_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [QI_W-1:0]   found_index;
        logic [MOD_W-1:0]  out_module_id;
        logic [DATA_W-1:0] out_msg_handle;
        logic [DATA_W-1:0] out_msg_source;
        logic [QI_W-1:0]   pending_count;
        logic              callback_found;
        logic [QI_W-1:0]   callback_index;
    } res_t;

endpackage

/* src/pmmq_engine.sv */
// Queue and message memories with the sequencer that walks them.
`include "per_module_message_queue_assert.svh"

module pmmq_engine
    import pmmq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [MODULE_COUNT-1:0] callback_mask,
    input  logic                    start,
    input  cmd_t                    cmd,
    output logic                    idle,
    output logic                    res_valid,
    input  logic                    res_take,
    output res_t                    res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QRD    = 4'd1;
    localparam logic [3:0] S_QWT    = 4'd2;
    localparam logic [3:0] S_TK_MD  = 4'd3;
    localparam logic [3:0] S_QSH_RD = 4'd4;
    localparam logic [3:0] S_QSH_WR = 4'd5;
    localparam logic [3:0] S_MSH_RD = 4'd6;
    localparam logic [3:0] S_MSH_WR = 4'd7;
    localparam logic [3:0] S_APPEND = 4'd8;
    localparam logic [3:0] S_FM_RD  = 4'd9;
    localparam logic [3:0] S_FM_CHK = 4'd10;
    localparam logic [3:0] S_FS_RD  = 4'd11;
    localparam logic [3:0] S_FS_CHK = 4'd12;
    localparam logic [3:0] S_CB_RD  = 4'd13;
    localparam logic [3:0] S_CB_CHK = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    localparam logic [IDX_W-1:0] DEPTH_V = IDX_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] ONE_V   = IDX_W'(1);

    logic [MOD_W-1:0]    qmem [QUEUE_DEPTH];
    logic [2*DATA_W-1:0] mmem [MODULE_COUNT*QUEUE_DEPTH];

    logic [3:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [QI_W-1:0]    count_reg, count_next;
    logic [QI_W-1:0]    cnt_reg [MODULE_COUNT];
    logic [QI_W-1:0]    cnt_next [MODULE_COUNT];
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [QI_W-1:0]    mpos_reg, mpos_next;
    logic [MOD_W-1:0]   m_reg, m_next;
    res_t               out_reg, out_next;

    logic                q_we;
    logic [QI_W-1:0]     q_waddr, q_raddr;
    logic [MOD_W-1:0]    q_wdata, q_rdata;
    logic                m_we;
    logic [MADDR_W-1:0]  m_waddr, m_raddr;
    logic [2*DATA_W-1:0] m_wdata, m_rdata;

    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] count_ext;
    logic [IDX_W-1:0] mcnt_ext;

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_waddr] <= q_wdata;
        end
        q_rdata <= qmem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mmem[m_waddr] <= m_wdata;
        end
        m_rdata <= mmem[m_raddr];
    end

    assign idx_inc   = idx_reg + ONE_V;
    assign count_ext = {1'b0, count_reg};
    assign mcnt_ext  = {1'b0, cnt_reg[m_reg]};

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        mpos_next  = mpos_reg;
        m_next     = m_reg;
        out_next   = out_reg;
        q_we    = 1'b0;
        q_waddr = idx_reg[QI_W-1:0];
        q_wdata = q_rdata;
        q_raddr = idx_reg[QI_W-1:0];
        m_we    = 1'b0;
        m_waddr = {m_reg, idx_reg[QI_W-1:0]};
        m_wdata = m_rdata;
        m_raddr = {m_reg, idx_reg[QI_W-1:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    out_next = '0;
                    idx_next = '0;
                    case (cmd.opcode)
                        OP_PUSH:
                        begin
                            state_next = S_APPEND;
                            if (!((count_ext + ONE_V) < DEPTH_V &&
                                  ({1'b0, cnt_reg[cmd.module_id]} + ONE_V) < DEPTH_V))
                            begin
                                out_next.status = ST_DROPPED;
                                if (count_reg != '0)
                                begin
                                    cmd_next.queue_index = '0;
                                    state_next = S_QRD;
                                end
                            end
                        end
                        OP_FIND_MOD:
                        begin
                            out_next.status = ST_NOT_FOUND;
                            state_next = S_FM_RD;
                        end
                        default:
                        begin
                            if (cmd.queue_index >= count_reg)
                            begin
                                out_next.status = ST_BAD_INDEX;
                                state_next = S_CB_RD;
                            end
                            else
                            begin
                                state_next = S_QRD;
                            end
                        end
                    endcase
                end
            end
            S_QRD:
            begin
                q_raddr    = cmd_reg.queue_index;
                state_next = S_QWT;
            end
            S_QWT:
            begin
                m_next = q_rdata;
                case (cmd_reg.opcode)
                    OP_PUSH:
                    begin
                        idx_next   = '0;
                        mpos_next  = '0;
                        state_next = S_QSH_RD;
                    end
                    OP_TAKE:
                    begin
                        if (cmd_reg.list_index >= cnt_reg[q_rdata])
                        begin
                            out_next.status = ST_BAD_INDEX;
                            state_next = S_CB_RD;
                        end
                        else
                        begin
                            m_raddr    = {q_rdata, cmd_reg.list_index};
                            state_next = S_TK_MD;
                        end
                    end
                    default:
                    begin
                        out_next.status = ST_NOT_FOUND;
                        idx_next   = '0;
                        state_next = S_FS_RD;
                    end
                endcase
            end
            S_TK_MD:
            begin
                // message data read at the take address lands here
                out_next.out_module_id  = m_reg;
                out_next.out_msg_source = m_rdata[2*DATA_W-1:DATA_W];
                out_next.out_msg_handle = m_rdata[DATA_W-1:0];
                idx_next   = {1'b0, cmd_reg.queue_index};
                mpos_next  = cmd_reg.list_index;
                state_next = S_QSH_RD;
            end
            S_QSH_RD:
            begin
                if (idx_inc < count_ext)
                begin
                    q_raddr    = idx_inc[QI_W-1:0];
                    state_next = S_QSH_WR;
                end
                else
                begin
                    count_next = count_reg - QI_W'(1);
                    idx_next   = {1'b0, mpos_reg};
                    state_next = S_MSH_RD;
                end
            end
            S_QSH_WR:
            begin
                q_we       = 1'b1;
                idx_next   = idx_inc;
                state_next = S_QSH_RD;
            end
            S_MSH_RD:
            begin
                if ({1'b0, mpos_reg} < mcnt_ext && idx_inc < mcnt_ext)
                begin
                    m_raddr    = {m_reg, idx_inc[QI_W-1:0]};
                    state_next = S_MSH_WR;
                end
                else
                begin
                    if ({1'b0, mpos_reg} < mcnt_ext)
                    begin
                        cnt_next[m_reg] = cnt_reg[m_reg] - QI_W'(1);
                    end
                    idx_next   = '0;
                    state_next = (cmd_reg.opcode == OP_PUSH) ? S_APPEND : S_CB_RD;
                end
            end
            S_MSH_WR:
            begin
                m_we       = 1'b1;
                idx_next   = idx_inc;
                state_next = S_MSH_RD;
            end
            S_APPEND:
            begin
                q_we    = 1'b1;
                q_waddr = count_reg;
                q_wdata = cmd_reg.module_id;
                count_next = count_reg + QI_W'(1);
                m_we    = 1'b1;
                m_waddr = {cmd_reg.module_id, cnt_reg[cmd_reg.module_id]};
                m_wdata = {cmd_reg.msg_source, cmd_reg.msg_handle};
                cnt_next[cmd_reg.module_id] = cnt_reg[cmd_reg.module_id] + QI_W'(1);
                idx_next   = '0;
                state_next = S_CB_RD;
            end
            S_FM_RD:
            begin
                if (idx_reg < count_ext)
                begin
                    state_next = S_FM_CHK;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_CB_RD;
                end
            end
            S_FM_CHK:
            begin
                if (q_rdata == cmd_reg.module_id)
                begin
                    out_next.status      = ST_DONE;
                    out_next.found_index = idx_reg[QI_W-1:0];
                    idx_next   = '0;
                    state_next = S_CB_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FM_RD;
                end
            end
            S_FS_RD:
            begin
                if (idx_reg < mcnt_ext)
                begin
                    state_next = S_FS_CHK;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_CB_RD;
                end
            end
            S_FS_CHK:
            begin
                if (m_rdata[2*DATA_W-1:DATA_W] == cmd_reg.msg_source)
                begin
                    out_next.status      = ST_DONE;
                    out_next.found_index = idx_reg[QI_W-1:0];
                    idx_next   = '0;
                    state_next = S_CB_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FS_RD;
                end
            end
            S_CB_RD:
            begin
                state_next = (idx_reg < count_ext) ? S_CB_CHK : S_DONE;
            end
            S_CB_CHK:
            begin
                if (callback_mask[q_rdata])
                begin
                    out_next.callback_found = 1'b1;
                    out_next.callback_index = idx_reg[QI_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_CB_RD;
                end
            end
            S_DONE:
            begin
                out_next.pending_count = count_reg;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            for (int k = 0; k < MODULE_COUNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        mpos_reg <= mpos_next;
        m_reg    <= m_next;
        out_reg  <= out_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res = out_reg;
        res.pending_count = count_reg;
    end

    `PMMQ_ASSERT_NOW(a_append_room, state_reg == S_APPEND, count_reg != '1)
    `PMMQ_ASSERT_NOW(a_shift_in_range, state_reg == S_QSH_WR, idx_inc < count_ext)
    `PMMQ_ASSERT_NOW(a_drop_only_push,
        state_reg == S_DONE && out_reg.status == ST_DROPPED, cmd_reg.opcode == OP_PUSH)
    `PMMQ_ASSERT_NEXT(a_take_leaves, state_reg == S_DONE && res_take, state_reg == S_IDLE)

endmodule

/* src/per_module_message_queue.sv */
// Top level: stream ports, callback mask register and result register.
//
//  channel | direction | carries
//  s_axis  | in        | tuser opcode; tdata module, handle, source, queue and list index
//  m_axis  | out       | tuser status; tdata found, module, handle, source, count, callback
//  cfg     | in        | callback_mask, one bit per module
//
// One item at a time; each entry walked by a shift-down, a search or the callback scan
// takes a read step, then a write or check step, set by the single read port of each
// memory. Slowest case: a push that drops the oldest of 15 entries of one module; the
// next input transfer is taken once the engine is back in its idle state. No clearing pass:
// only counts reset. A stalled output holds the engine in its last step.
module per_module_message_queue
    import pmmq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // opcode
    input  logic [47:0] s_axis_tdata,   // module_id, msg_handle, msg_source, queue_index,
                                        // list_index, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // status
    output logic [47:0] m_axis_tdata    // found_index, out_module_id, out_msg_handle,
                                        // out_msg_source, pending_count, callback_found,
                                        // callback_index
);

    logic [MODULE_COUNT-1:0] mask_reg;
    logic                    m_valid_reg;
    res_t                    m_data_reg;
    cmd_t                    cmd;
    res_t                    res;
    logic                    idle;
    logic                    res_valid;
    logic                    res_take;

    assign cmd.opcode      = s_axis_tuser;
    assign cmd.module_id   = s_axis_tdata[2:0];
    assign cmd.msg_handle  = s_axis_tdata[18:3];
    assign cmd.msg_source  = s_axis_tdata[34:19];
    assign cmd.queue_index = s_axis_tdata[38:35];
    assign cmd.list_index  = s_axis_tdata[42:39];

    assign s_axis_tready = idle;
    assign res_take      = !m_valid_reg || m_axis_tready;

    pmmq_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .callback_mask (mask_reg),
        .start         (s_axis_tvalid),
        .cmd           (cmd),
        .idle          (idle),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (res_valid && res_take)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until its transfer completes
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_data_reg.status;
    assign m_axis_tdata  = {m_data_reg.callback_index, m_data_reg.callback_found,
                            m_data_reg.pending_count, m_data_reg.out_msg_source,
                            m_data_reg.out_msg_handle, m_data_reg.out_module_id,
                            m_data_reg.found_index};

endmodule
